[rtl/core/double_ended_queue_unit_defines.svh]
// assertion macros used by the double ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define DEQ_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// next-cycle implication
`define DEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

[rtl/core/deq_pkg.sv]
// types and constants of the double ended queue
`default_nettype none

package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic load_back;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/deq_cell.sv]
// one storage cell of the deque shift chain
`default_nettype none

module deq_cell (
   input  wire logic                           clock,
   input  wire deq_pkg::cell_ctrl_type         ctrl,
   input  wire logic [deq_pkg::DATA_WIDTH-1:0] left_data,
   input  wire logic [deq_pkg::DATA_WIDTH-1:0] right_data,
   input  wire logic [deq_pkg::DATA_WIDTH-1:0] item_data,
   output logic      [deq_pkg::DATA_WIDTH-1:0] data
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      if (ctrl.shift_right) begin
         data_in = left_data;
      end else if (ctrl.shift_left) begin
         data_in = right_data;
      end else if (ctrl.load_back) begin
         data_in = item_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[rtl/core/double_ended_queue_unit.sv]
// a push or pop at the front shifts every cell of the chain, a push at the back loads one cell
// throughput: one transaction per cycle while rsp_tready is high or no response is held
// the response register frees when rsp_tready is high, so input and output run in parallel
// reset: synchronous, clears the fill count and the response valid
// cell contents are unknown after reset and only occupied cells are ever read
`default_nettype none
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // op[2:0], item[34:3], zero[39:35]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata    // data_out[31:0], status[33:32], occupancy[38:34], is_empty[39]
);
   import deq_pkg::*;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [39:0]           rsp_data_ff;
   logic [39:0]           rsp_data_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   logic                  fire;
   op_type                op;
   logic [DATA_WIDTH-1:0] item_w;
   logic                  full;
   logic                  empty;
   logic [PTR_W-1:0]      back_idx;
   logic                  do_push_front;
   logic                  do_push_back;
   logic                  do_pop_front;
   logic [DATA_WIDTH-1:0] read_data;
   status_type            status;
   logic [31:0]           data_out;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   cell_ctrl_type         cell_ctrl [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign op         = op_type'(req_tdata[2:0]);
   assign item_w     = DATA_WIDTH'(req_tdata[34:3]);
   assign full       = count_ff == CNT_W'(DEPTH);
   assign empty      = count_ff == '0;
   assign back_idx   = PTR_W'(count_ff - CNT_W'(1));

   assign do_push_front = fire && (op == OP_PUSH_FRONT) && !full;
   assign do_push_back  = fire && (op == OP_PUSH_BACK) && !full;
   assign do_pop_front  = fire && (op == OP_POP_FRONT) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = item_w;
      end else begin : g_inner_left
         assign left_w = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner_right
         assign right_w = cell_data[i+1];
      end

      assign cell_ctrl[i].shift_right = do_push_front;
      assign cell_ctrl[i].shift_left  = do_pop_front;
      assign cell_ctrl[i].load_back   = do_push_back && (count_ff == CNT_W'(i));

      deq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .left_data  (left_w),
         .right_data (right_w),
         .item_data  (item_w),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status    = ST_OK;
      read_data = '0;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               read_data = cell_data[0];
               count_in  = count_ff - CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               read_data = cell_data[back_idx];
               count_in  = count_ff - CNT_W'(1);
            end
         end
         OP_PEEK_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               read_data = cell_data[0];
            end
         end
         OP_PEEK_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               read_data = cell_data[back_idx];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign data_out     = 32'(read_data);
   assign rsp_data_in  = {count_in == '0, 5'(count_in), status, data_out};
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `DEQ_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `DEQ_ASSERT_NEXT(a_push_grows, clock, reset, do_push_front || do_push_back, count_ff == $past(count_ff) + CNT_W'(1))
   `DEQ_ASSERT_NOW(a_empty_flag, clock, reset, rsp_valid_ff, rsp_data_ff[39] == (rsp_data_ff[38:34] == 5'd0))
   `DEQ_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid_ff && (rsp_data_ff[33:32] != ST_OK), rsp_data_ff[31:0] == 32'd0)

endmodule

`default_nettype wire

[tb/tb_double_ended_queue_unit.sv]
// self-checking testbench for the double ended queue unit, directed table then random traffic
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
   import deq_pkg::*;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int PLAN_LEN    = 19;
   localparam int RANDOM_LEN  = 1920;
   localparam int QUIET_LEN   = 200;
   localparam int CHUNK_LEN   = 32;
   localparam int DRAIN_WAIT  = 4;

   typedef struct packed {
      logic [31:0] data;
      status_type  status;
      logic [4:0]  occ;
      logic        empty;
   } deq_result_type;

   typedef struct packed {
      logic           typed;
      deq_result_type res;
   } typed_answer_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] item;
      logic [4:0]  reps;
      logic        typed;
      logic [31:0] exp_data;
      status_type  exp_status;
      logic [4:0]  exp_occ;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   logic [31:0] shadow_slots [DEPTH];
   int          shadow_head;
   int          shadow_tail;
   int          shadow_fill;

   deq_result_type   pending_results [$];
   typed_answer_type typed_answers [$];
   int               mismatch_count;
   bit               quiet;
   int               stall_left;

   stim_row_type plan [PLAN_LEN] = '{
      '{OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_POP_BACK,   32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_PEEK_BACK,  32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
      '{OP_SPARE_6,    32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0000_0000, ST_OK,    5'd1},
      '{OP_PUSH_BACK,  32'h0000_0000, 5'd1, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
      '{OP_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b1, 32'hFFFF_FFFF, ST_OK,    5'd2},
      '{OP_PEEK_BACK,  32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
      '{OP_SPARE_7,    32'h1234_5678, 5'd1, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
      '{OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1, 32'h0000_0000, ST_OK,    5'd1},
      '{OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1, 32'hFFFF_FFFF, ST_OK,    5'd0},
      // head wraps below slot zero, then the queue fills up
      '{OP_PUSH_FRONT, 32'h1357_9BDF, 5'd8, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_PUSH_BACK,  32'hECA8_6420, 5'd8, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_PUSH_FRONT, 32'h0BAD_F00D, 5'd1, 1'b1, 32'h0000_0000, ST_FULL,  5'd16},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0000_0000, ST_FULL,  5'd16},
      '{OP_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_PEEK_BACK,  32'h0000_0000, 5'd1, 1'b0, 32'h0000_0000, ST_OK,    5'd0},
      '{OP_SPARE_6,    32'h0000_0000, 5'd1, 1'b1, 32'h0000_0000, ST_OK,    5'd16}
   };

   double_ended_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   function automatic int step_up(input int idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
   endfunction

   function automatic int step_down(input int idx);
      return (idx == 0) ? DEPTH - 1 : idx - 1;
   endfunction

   // advances the shadow deque by one request and returns its response
   function automatic deq_result_type apply_request(input logic [2:0] op,
                                                    input logic [31:0] word);
      deq_result_type res;
      res = '{data: 32'h0, status: ST_OK, occ: 5'd0, empty: 1'b0};
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_fill >= DEPTH) begin
               res.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               shadow_head = step_down(shadow_head);
               shadow_slots[shadow_head] = word;
               shadow_fill++;
            end else begin
               shadow_slots[shadow_tail] = word;
               shadow_tail = step_up(shadow_tail);
               shadow_fill++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
               res.data = shadow_slots[shadow_head];
               shadow_head = step_up(shadow_head);
               shadow_fill--;
            end else if (op == OP_POP_BACK) begin
               shadow_tail = step_down(shadow_tail);
               res.data = shadow_slots[shadow_tail];
               shadow_fill--;
            end else if (op == OP_PEEK_FRONT) begin
               res.data = shadow_slots[shadow_head];
            end else begin
               res.data = shadow_slots[step_down(shadow_tail)];
            end
         end
         default: begin
         end
      endcase
      res.occ   = shadow_fill[4:0];
      res.empty = (shadow_fill == 0);
      return res;
   endfunction

   // presents one transaction, idling first at random, and returns at its accepting edge
   task automatic send_request(input logic [2:0] op, input logic [31:0] word,
                               input logic typed, input deq_result_type answer);
      typed_answer_type ta;
      ta.typed = typed;
      ta.res   = answer;
      typed_answers.push_back(ta);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, word, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // response side stalls in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 5) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // scoreboard: check responses first, since a response never belongs to this edge's request
   always @(posedge clock) begin
      deq_result_type   got;
      deq_result_type   want;
      deq_result_type   predicted;
      typed_answer_type ta;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.data   = rsp_tdata[31:0];
            got.status = status_type'(rsp_tdata[33:32]);
            got.occ    = rsp_tdata[38:34];
            got.empty  = rsp_tdata[39];
            if (pending_results.size() == 0) begin
               $display("%0t: response with nothing expected, got %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.data !== want.data) begin
                  $display("%0t: data_out expected %h actual %h", $time, want.data, got.data);
                  mismatch_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           got.status);
                  mismatch_count++;
               end
               if (got.occ !== want.occ) begin
                  $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, got.occ);
                  mismatch_count++;
               end
               if (got.empty !== want.empty) begin
                  $display("%0t: is_empty expected %b actual %b", $time, want.empty,
                           got.empty);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predicted = apply_request(req_tdata[2:0], req_tdata[34:3]);
            ta = typed_answers.pop_front();
            pending_results.push_back(ta.typed ? ta.res : predicted);
         end
      end
   end

   initial begin
      deq_result_type answer;
      deq_result_type none;
      logic [2:0]     op;
      logic [31:0]    word;
      int             mode;
      int             push_weight;
      int             pick;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      stall_left     = 0;
      quiet          = 1'b0;
      mismatch_count = 0;
      shadow_head    = 0;
      shadow_tail    = 0;
      shadow_fill    = 0;
      none = '{data: 32'h0, status: ST_OK, occ: 5'd0, empty: 1'b0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         answer.data   = plan[r].exp_data;
         answer.status = plan[r].exp_status;
         answer.occ    = plan[r].exp_occ;
         answer.empty  = (plan[r].exp_occ == 5'd0);
         repeat (plan[r].reps) send_request(plan[r].op, plan[r].item, plan[r].typed, answer);
      end

      mode = 1;
      for (int i = 0; i < RANDOM_LEN; i++) begin
         if (i % CHUNK_LEN == 0 && i != 0) mode = $urandom_range(0, 2);
         if (i >= RANDOM_LEN - QUIET_LEN) quiet = 1'b1;
         // fill, drain or balanced traffic so both full and empty are reached often
         push_weight = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
         end else if (pick < push_weight + 3) begin
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else if ($urandom_range(0, 9) < 7) begin
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
         end
         if ($urandom_range(0, 9) == 0) begin
            word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         end else begin
            word = $urandom;
         end
         send_request(op, word, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: responses outstanding expected 0 actual %0d", $time,
                  pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_unit.sv
tb/tb_double_ended_queue_unit.sv
